### rtl/rchc_pkg.sv
`default_nettype none
package rchc_pkg;

	// Histogram geometry
	localparam int HIST_BINS = 64;
	localparam int BIN_W = $clog2(HIST_BINS);
	localparam int PW = BIN_W + 1;
	localparam int TOP_HARMONIC = 6;

	// Field and state widths
	localparam int TS_W = 40;
	localparam int BW_W = 20;
	localparam int CNT_W = 31;
	localparam int ACC_W = 64;
	localparam int PROD_W = 2 * ACC_W;
	localparam int REG_W = 16;
	localparam int PER_W = 28;
	localparam int CLS_W = 3;
	localparam int OUT_W = 80;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	// Shared divider and square root sizes
	localparam int DIV_W = 80;
	localparam int DIVR_W = 64;
	localparam int DIVS_W = $clog2(DIV_W + 1);
	localparam int SHORT_STEPS = TS_W + 8;
	localparam int ROOT_W = 80;

	localparam logic [BW_W-1:0] BW_DEFAULT = BW_W'(256);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [PER_W-1:0] PERIOD_MAX = '1;

	// Operation codes carried on the input kind field
	localparam logic [1:0] FUNC_OBSERVE = 2'd0;
	localparam logic [1:0] FUNC_ESTIMATE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// Cadence classes
	localparam logic [CLS_W-1:0] CLASS_ONCE = 3'd0;
	localparam logic [CLS_W-1:0] CLASS_NEAR = 3'd1;
	localparam logic [CLS_W-1:0] CLASS_PERIODIC = 3'd2;
	localparam logic [CLS_W-1:0] CLASS_QUASI = 3'd3;
	localparam logic [CLS_W-1:0] CLASS_EVENT = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OBS_SUM,
		ST_OBS_DIV,
		ST_OBS_WR,
		ST_EST_MUL1,
		ST_EST_MUL2,
		ST_EST_CHK,
		ST_EST_SQRT,
		ST_EST_DIVR,
		ST_EST_CLASS,
		ST_EST_DIVP,
		ST_EST_DIV6,
		ST_EST_SCAN1,
		ST_EST_SCAN2,
		ST_EST_FINAL,
		ST_DONE
	} state_t;

	// Status of a multi-cycle arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// Control of the histogram memory
	typedef struct packed {
		logic clear;
		logic rd_en;
		logic [BIN_W-1:0] rd_addr;
		logic wr_en;
		logic [BIN_W-1:0] wr_addr;
	} hist_req_t;

endpackage
`default_nettype wire

### rtl/rchc_hist_ram.sv
`default_nettype none
module rchc_hist_ram (
	input wire logic clk,
	input wire logic arst_n,
	input wire rchc_pkg::hist_req_t req,
	input wire logic [rchc_pkg::CNT_W-1:0] wr_data,
	output logic [rchc_pkg::CNT_W-1:0] rd_data
);
	import rchc_pkg::*;

	logic [CNT_W-1:0] mem_q [HIST_BINS];
	logic [HIST_BINS-1:0] valid_q;
	logic [CNT_W-1:0] rd_q;
	logic rd_vld_q;

	// Storage array with a registered read port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem_q[req.rd_addr];
		end
	end

	// Per-bin valid bits give the cleared value without sweeping the array.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

### rtl/rchc_mul.sv
`default_nettype none
module rchc_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [rchc_pkg::ACC_W-1:0] a,
	input wire logic [rchc_pkg::ACC_W-1:0] b,
	output logic [rchc_pkg::PROD_W-1:0] product,
	output rchc_pkg::unit_stat_t stat
);
	import rchc_pkg::*;

	localparam int MC_W = $clog2(ACC_W + 1);

	logic [PROD_W-1:0] a_q;
	logic [ACC_W-1:0] b_q;
	logic [PROD_W-1:0] acc_q;
	logic [MC_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	// Shift-and-add, one multiplier bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= PROD_W'(a);
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= MC_W'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign product = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

### rtl/rchc_div.sv
`default_nettype none
module rchc_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [rchc_pkg::DIV_W-1:0] dividend,
	input wire logic [rchc_pkg::DIVR_W-1:0] divisor,
	input wire logic [rchc_pkg::DIVS_W-1:0] steps,
	output logic [rchc_pkg::DIV_W-1:0] quotient,
	output rchc_pkg::unit_stat_t stat
);
	import rchc_pkg::*;

	logic [DIV_W-1:0] dvd_q;
	logic [DIVR_W-1:0] dsr_q;
	logic [DIVR_W:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIVS_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIVR_W:0] trial;
	logic ge;

	// Restoring division, one quotient bit per cycle. The dividend arrives
	// left aligned, so the step count selects how many of its bits are used.
	assign trial = {rem_q[DIVR_W-1:0], dvd_q[DIV_W-1]};
	assign ge = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, dsr_q} : trial;
			quo_q <= {quo_q[DIV_W-2:0], ge};
			dvd_q <= dvd_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIVS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

### rtl/rchc_sqrt.sv
`default_nettype none
module rchc_sqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [rchc_pkg::PROD_W-1:0] radicand,
	output logic [rchc_pkg::ROOT_W-1:0] root,
	output rchc_pkg::unit_stat_t stat
);
	import rchc_pkg::*;

	localparam int RAD_W = 2 * ROOT_W;
	localparam int SC_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0] rad_q;
	logic [ROOT_W:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SC_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [ROOT_W+2:0] rem_n;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] rem_sub;
	logic ge;

	// Digit-by-digit integer square root of radicand * 2^32, two radicand
	// bits per cycle.
	assign rem_n = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge = rem_n >= trial;
	assign rem_sub = rem_n - trial;

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= {radicand, {(RAD_W - PROD_W){1'b0}}};
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			rem_q <= ge ? rem_sub[ROOT_W:0] : rem_n[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= SC_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

### rtl/running_cadence_histogram_classifier_core.sv
// Channel   Direction  Transfer                 Contents
// s_*       in         s_tvalid & s_tready      tuser: func, tdata: timestamp
// m_*       out        m_tvalid & m_tready      tdata: class, period, regularity, count
// APB       in/out     psel & penable & pwrite  bin_width at byte address 0
//
// An observe with a positive interval holds s_tready low while it updates the sums, runs
// the 48-step serial divider that finds the bin and writes the bin back.
// An estimate with samples forms two shift-add products; if the total is nonzero and the
// standard deviation is below the mean, an 80-step square root and an 80-step divide
// follow, then a 48-step divide for a near-continuous period or up to two 64-bin walks
// through the histogram memory. An estimate with no samples goes straight to its result.
// Reset and clear zero the histogram at once through per-bin valid bits.
// A finished result waits in the output register; the next item is accepted meanwhile.
`default_nettype none
module running_cadence_histogram_classifier_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [rchc_pkg::TS_W-1:0] s_tdata,   // [39:0] timestamp
	input wire logic [1:0] s_tuser,                   // [1:0] func
	output logic m_tvalid,
	input wire logic m_tready,
	// [2:0] cadence_class, [30:3] period, [46:31] regularity, [77:47] sample_count
	output logic [rchc_pkg::OUT_W-1:0] m_tdata,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [rchc_pkg::CFG_AW-1:0] paddr,
	input wire logic [rchc_pkg::CFG_DW-1:0] pwdata,
	output logic [rchc_pkg::CFG_DW-1:0] prdata,
	output logic pready
);
	import rchc_pkg::*;

	localparam int FW = PW + 6;
	localparam int ACW = CNT_W + BIN_W;
	localparam int WRW = CNT_W + PW + BIN_W;
	localparam int CMPW = WRW + 3;

	// Fold a bin centre onto a harmonic of the fundamental: returns {support, residual}.
	function automatic logic [PW:0] fold_bin(input logic [BIN_W-1:0] b,
			input logic [PW-1:0] p);
		logic [FW-1:0] x;
		logic [FW-1:0] x2p;
		logic [FW-1:0] mp;
		logic [FW-1:0] e;
		logic [FW-1:0] e2;
		logic [FW-1:0] num2;
		logic [2:0] m;
		logic sup;
		x = FW'({b, 1'b1});
		x2p = (x << 1) + FW'(p);
		m = 3'd1;
		for (int k = 2; k <= TOP_HARMONIC; k++) begin
			if (((FW'(p) * FW'(k)) << 1) <= x2p) begin
				m = 3'(k);
			end
		end
		mp = FW'(p) * FW'(m);
		e = (x >= mp) ? x - mp : mp - x;
		e2 = e << 1;
		num2 = (e2 < FW'(p)) ? e2 : FW'(p);
		sup = (num2 * FW'(25)) <= (FW'(p) * FW'(9));
		return {sup, num2[PW-1:0]};
	endfunction

	state_t state_q, state_d;

	// Model state
	logic [BW_W-1:0] bin_width_q;
	logic have_last_q;
	logic [TS_W-1:0] last_time_q;
	logic [ACC_W-1:0] total_q;
	logic [ACC_W-1:0] sqtotal_q;
	logic [CNT_W-1:0] count_q;

	// Working registers
	logic [TS_W-1:0] d_q;
	logic [ACC_W-1:0] sq_q;
	logic [BIN_W-1:0] bin_q;
	logic [PROD_W-1:0] nq_q;
	logic [PROD_W-1:0] s2_q;
	logic [PROD_W-1:0] v_q;
	logic [REG_W-1:0] regl_q;
	logic [CLS_W-1:0] class_q;
	logic [PER_W-1:0] period_q;
	logic [CNT_W-1:0] minsup_q;
	logic [BIN_W-1:0] f_q;
	logic [BIN_W:0] issue_q;
	logic vld_s1;
	logic [BIN_W-1:0] bin_s1;
	logic [PW-1:0] num2_s1;
	logic sup_s1;
	logic [ACW-1:0] tot_q;
	logic [ACW-1:0] onm_q;
	logic [WRW-1:0] wres_q;
	logic m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	// Unit connections
	logic div_start;
	logic [DIV_W-1:0] div_dvd;
	logic [DIVR_W-1:0] div_dsr;
	logic [DIVS_W-1:0] div_steps;
	logic [DIV_W-1:0] div_q;
	unit_stat_t div_st;
	logic mul_start;
	logic [ACC_W-1:0] mul_a;
	logic [ACC_W-1:0] mul_b;
	logic [PROD_W-1:0] mul_p;
	unit_stat_t mul_st;
	logic sq_start;
	logic [ROOT_W-1:0] sq_root;
	unit_stat_t sq_st;
	hist_req_t hist_req;
	logic [CNT_W-1:0] hist_wdata;
	logic [CNT_W-1:0] hist_rd;

	// Misc combinational values
	logic in_acc;
	logic out_free;
	logic out_load;
	logic cfg_wr;
	logic interval_ok;
	logic near;
	logic [BW_W-1:0] eff_w;
	logic [PW-1:0] p_w;
	logic [BIN_W-1:0] bin_clamp;
	logic [ACC_W-1:0] sq_prod;
	logic [ACC_W:0] tsum;
	logic [ACC_W:0] qsum;
	logic [PROD_W-1:0] v_calc;
	logic [REG_W:0] r17;
	logic [REG_W-1:0] regl_calc;
	logic [PW:0] fold_res;
	logic [ACW+1:0] sup_lhs;
	logic [ACW+1:0] sup_rhs;
	logic [CMPW-1:0] wres5;
	logic [CMPW-1:0] ptot;
	logic [63:0] per64;
	logic [63:0] sixth_prod;
	logic [CNT_W-1:0] n_sixth;
	logic last_bin_s1;
	logic issue_more;

	rchc_hist_ram u_hist (
		.clk(clk),
		.arst_n(arst_n),
		.req(hist_req),
		.wr_data(hist_wdata),
		.rd_data(hist_rd)
	);

	rchc_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.product(mul_p),
		.stat(mul_st)
	);

	rchc_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.radicand(v_q),
		.root(sq_root),
		.stat(sq_st)
	);

	rchc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dsr),
		.steps(div_steps),
		.quotient(div_q),
		.stat(div_st)
	);

	// Handshakes and configuration port
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? '0 : CFG_DW'(bin_width_q);

	// Shared arithmetic helpers
	assign eff_w = (bin_width_q == '0) ? BW_DEFAULT : bin_width_q;
	assign interval_ok = have_last_q && (s_tdata > last_time_q);
	assign near = total_q < {{(ACC_W - CNT_W - 1){1'b0}}, count_q, 1'b0};
	assign p_w = {f_q, 1'b1};
	assign bin_clamp = (div_q >= DIV_W'(HIST_BINS)) ? BIN_W'(HIST_BINS - 1)
		: div_q[BIN_W-1:0];
	assign sq_prod = (|d_q[TS_W-1:32]) ? '1 : d_q[31:0] * d_q[31:0];
	assign tsum = {1'b0, total_q} + (ACC_W + 1)'(d_q);
	assign qsum = {1'b0, sqtotal_q} + {1'b0, sq_q};
	assign v_calc = (nq_q >= mul_p) ? nq_q - mul_p : '0;
	assign r17 = (REG_W + 1)'(1 << REG_W) - div_q[REG_W:0];
	assign regl_calc = (|div_q[DIV_W-1:REG_W]) ? '0 : (r17[REG_W] ? '1 : r17[REG_W-1:0]);
	assign fold_res = fold_bin(issue_q[BIN_W-1:0], p_w);
	assign sup_lhs = {onm_q, 2'b00};
	assign sup_rhs = (ACW + 2)'(tot_q) * (ACW + 2)'(3);
	assign wres5 = CMPW'(wres_q) * CMPW'(5);
	assign ptot = CMPW'(p_w) * CMPW'(tot_q);
	assign per64 = (64'(p_w) * 64'(eff_w)) >> 1;
	// A sixth of the count: halve it, then divide by three with a reciprocal multiply.
	assign sixth_prod = 64'(count_q[CNT_W-1:1]) * 64'(32'hAAAA_AAAB);
	assign n_sixth = sixth_prod[63:33];
	assign last_bin_s1 = (bin_s1 == BIN_W'(HIST_BINS - 1));
	assign issue_more = (issue_q < (BIN_W + 1)'(HIST_BINS));
	assign hist_wdata = (hist_rd == CNT_MAX) ? CNT_MAX : hist_rd + 1'b1;

	// Sequencer: next state, unit starts and memory accesses.
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_dvd = '0;
		div_dsr = '0;
		div_steps = '0;
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		sq_start = 1'b0;
		hist_req = '0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (s_tuser)
						FUNC_OBSERVE: begin
							if (interval_ok) begin
								state_d = ST_OBS_SUM;
							end
						end
						FUNC_ESTIMATE: begin
							if (count_q == '0) begin
								state_d = ST_DONE;
							end else begin
								mul_start = 1'b1;
								mul_a = ACC_W'(count_q);
								mul_b = sqtotal_q;
								state_d = ST_EST_MUL1;
							end
						end
						FUNC_CLEAR: begin
							hist_req.clear = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_OBS_SUM: begin
				div_start = 1'b1;
				div_dvd = {d_q, 8'b0, {(DIV_W - SHORT_STEPS){1'b0}}};
				div_dsr = DIVR_W'(eff_w);
				div_steps = DIVS_W'(SHORT_STEPS);
				state_d = ST_OBS_DIV;
			end
			ST_OBS_DIV: begin
				if (div_st.done) begin
					hist_req.rd_en = 1'b1;
					hist_req.rd_addr = bin_clamp;
					state_d = ST_OBS_WR;
				end
			end
			ST_OBS_WR: begin
				hist_req.wr_en = 1'b1;
				hist_req.wr_addr = bin_q;
				state_d = ST_IDLE;
			end
			ST_EST_MUL1: begin
				if (mul_st.done) begin
					mul_start = 1'b1;
					mul_a = total_q;
					mul_b = total_q;
					state_d = ST_EST_MUL2;
				end
			end
			ST_EST_MUL2: begin
				if (mul_st.done) begin
					state_d = ST_EST_CHK;
				end
			end
			ST_EST_CHK: begin
				if (total_q == '0 || v_q >= s2_q) begin
					state_d = ST_EST_CLASS;
				end else begin
					sq_start = 1'b1;
					state_d = ST_EST_SQRT;
				end
			end
			ST_EST_SQRT: begin
				if (sq_st.done) begin
					div_start = 1'b1;
					div_dvd = DIV_W'(sq_root);
					div_dsr = total_q;
					div_steps = DIVS_W'(DIV_W);
					state_d = ST_EST_DIVR;
				end
			end
			ST_EST_DIVR: begin
				if (div_st.done) begin
					state_d = ST_EST_CLASS;
				end
			end
			ST_EST_CLASS: begin
				if (near) begin
					div_start = 1'b1;
					div_steps = DIVS_W'(SHORT_STEPS);
					div_dvd = {total_q[TS_W-1:0], 8'b0, {(DIV_W - SHORT_STEPS){1'b0}}};
					div_dsr = DIVR_W'(count_q);
					state_d = ST_EST_DIVP;
				end else begin
					state_d = ST_EST_DIV6;
				end
			end
			ST_EST_DIVP: begin
				if (div_st.done) begin
					state_d = ST_DONE;
				end
			end
			ST_EST_DIV6: begin
				state_d = ST_EST_SCAN1;
			end
			ST_EST_SCAN1: begin
				hist_req.rd_en = issue_more;
				hist_req.rd_addr = issue_q[BIN_W-1:0];
				if (vld_s1 && hist_rd >= minsup_q) begin
					state_d = ST_EST_SCAN2;
				end else if (vld_s1 && last_bin_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_EST_SCAN2: begin
				hist_req.rd_en = issue_more;
				hist_req.rd_addr = issue_q[BIN_W-1:0];
				if (vld_s1 && last_bin_s1) begin
					state_d = ST_EST_FINAL;
				end
			end
			ST_EST_FINAL: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register, configuration and the tracked statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bin_width_q <= BW_DEFAULT;
			have_last_q <= 1'b0;
			last_time_q <= '0;
			total_q <= '0;
			sqtotal_q <= '0;
			count_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				bin_width_q <= pwdata[BW_W-1:0];
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (s_tuser)
							FUNC_OBSERVE: begin
								last_time_q <= s_tdata;
								have_last_q <= 1'b1;
							end
							FUNC_CLEAR: begin
								have_last_q <= 1'b0;
								last_time_q <= '0;
								total_q <= '0;
								sqtotal_q <= '0;
								count_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_OBS_SUM: begin
					total_q <= tsum[ACC_W] ? '1 : tsum[ACC_W-1:0];
					if (count_q != CNT_MAX) begin
						count_q <= count_q + 1'b1;
					end
				end
				ST_OBS_DIV: begin
					if (div_st.done) begin
						sqtotal_q <= qsum[ACC_W] ? '1 : qsum[ACC_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the observe and estimate sequences.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				d_q <= s_tdata - last_time_q;
				regl_q <= '0;
				class_q <= CLASS_ONCE;
				period_q <= '0;
			end
			ST_OBS_SUM: begin
				sq_q <= sq_prod;
			end
			ST_OBS_DIV: begin
				bin_q <= bin_clamp;
			end
			ST_EST_MUL1: begin
				if (mul_st.done) begin
					nq_q <= mul_p;
				end
			end
			ST_EST_MUL2: begin
				s2_q <= mul_p;
				v_q <= v_calc;
			end
			ST_EST_DIVR: begin
				if (div_st.done) begin
					regl_q <= regl_calc;
				end
			end
			ST_EST_CLASS: begin
				class_q <= near ? CLASS_NEAR : CLASS_EVENT;
			end
			ST_EST_DIVP: begin
				period_q <= div_q[PER_W-1:0];
			end
			ST_EST_DIV6: begin
				minsup_q <= (n_sixth < CNT_W'(2)) ? CNT_W'(2) : n_sixth;
				issue_q <= '0;
				vld_s1 <= 1'b0;
			end
			ST_EST_SCAN1: begin
				if (vld_s1 && hist_rd >= minsup_q) begin
					f_q <= bin_s1;
					issue_q <= '0;
					vld_s1 <= 1'b0;
					tot_q <= '0;
					onm_q <= '0;
					wres_q <= '0;
				end else begin
					vld_s1 <= issue_more;
					bin_s1 <= issue_q[BIN_W-1:0];
					issue_q <= issue_q + (BIN_W + 1)'(issue_more);
				end
			end
			ST_EST_SCAN2: begin
				vld_s1 <= issue_more;
				bin_s1 <= issue_q[BIN_W-1:0];
				num2_s1 <= fold_res[PW-1:0];
				sup_s1 <= fold_res[PW];
				issue_q <= issue_q + (BIN_W + 1)'(issue_more);
				if (vld_s1) begin
					tot_q <= tot_q + ACW'(hist_rd);
					if (sup_s1) begin
						onm_q <= onm_q + ACW'(hist_rd);
					end
					wres_q <= wres_q + WRW'(hist_rd) * WRW'(num2_s1);
				end
			end
			ST_EST_FINAL: begin
				if (sup_lhs >= sup_rhs) begin
					class_q <= (wres5 <= ptot) ? CLASS_PERIODIC : CLASS_QUASI;
					period_q <= (per64 > 64'(PERIOD_MAX)) ? PERIOD_MAX : per64[PER_W-1:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_data_q <= {{(OUT_W - CNT_W - REG_W - PER_W - CLS_W){1'b0}},
						count_q, regl_q, period_q, class_q};
				end
			end
			default: ;
		endcase
	end

	// The arithmetic units are all quiet whenever a new item can enter.
	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_st.busy && !mul_st.busy && !sq_st.busy)
		else $error("arithmetic unit busy while accepting items");

	// A result is only loaded into a free output register.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !m_valid_q || m_tready)
		else $error("result overwrote a pending transaction");

	// Every histogram write is the update of the bin read in the cycle before.
	a_rmw_pair: assert property (@(posedge clk) disable iff (!arst_n)
		hist_req.wr_en |-> $past(hist_req.rd_en) && $past(hist_req.rd_addr) == hist_req.wr_addr)
		else $error("histogram write without matching read");

	// Clear and bin update never coincide.
	a_clear_wr: assert property (@(posedge clk) disable iff (!arst_n)
		hist_req.clear |-> !hist_req.wr_en && state_q == ST_IDLE)
		else $error("histogram clear during an update");

endmodule
`default_nettype wire
